>>> rtl/scv_pkg.sv
// Package for the status CSR views block: transaction and configuration types,
// command, view and register index codes, layout constants and helper functions.
// No dependencies.
`default_nettype none

package scv_pkg;

    localparam int unsigned XLEN = 64;

    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_SET   = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_MPP   = 3'd4;

    localparam logic [1:0] VIEW_MACHINE = 2'd0;
    localparam logic [1:0] VIEW_SUPER   = 2'd1;
    localparam logic [1:0] VIEW_USER    = 2'd2;

    localparam logic [2:0] CFG_RESET_VALUE   = 3'd0;
    localparam logic [2:0] CFG_VISIBLE_MASK  = 3'd1;
    localparam logic [2:0] CFG_MACHINE_WMASK = 3'd2;
    localparam logic [2:0] CFG_SUPER_WMASK   = 3'd3;
    localparam logic [2:0] CFG_USER_WMASK    = 3'd4;
    localparam logic [2:0] CFG_XLEN_IS_64    = 3'd5;
    localparam logic [2:0] CFG_HAS_USER      = 3'd6;
    localparam logic [2:0] CFG_HAS_SUPER     = 3'd7;

    localparam logic [XLEN-1:0] NARROW_COVER = 64'hC000_0000_03FF_FFFF;
    localparam logic [1:0]      XL_CODE_64   = 2'b10;
    localparam logic [1:0]      XL_CODE_32   = 2'b01;
    localparam int unsigned     MPP_LSB      = 11;

    typedef struct packed {
        logic [2:0]      command;
        logic [1:0]      view;
        logic            narrow_layout;
        logic [XLEN-1:0] data_value;
    } scv_req_t;

    typedef struct packed {
        logic [XLEN-1:0] read_data;
        logic            interrupt_check;
    } scv_rsp_t;

    typedef struct packed {
        logic [XLEN-1:0] reset_value;
        logic [XLEN-1:0] visible_mask;
        logic [XLEN-1:0] machine_write_mask;
        logic [XLEN-1:0] super_write_mask;
        logic [XLEN-1:0] user_write_mask;
        logic            xlen_is_64;
        logic            has_user;
        logic            has_supervisor;
    } scv_cfg_t;

    localparam scv_cfg_t CFG_AT_RESET = '{
        reset_value:        64'd0,
        visible_mask:       {XLEN{1'b1}},
        machine_write_mask: {XLEN{1'b1}},
        super_write_mask:   64'd0,
        user_write_mask:    64'd0,
        xlen_is_64:         1'b1,
        has_user:           1'b1,
        has_supervisor:     1'b1
    };

    function automatic logic [XLEN-1:0] scv_narrow_of(input logic [XLEN-1:0] v);
        return {32'd0, v[63:62], v[29:0]};
    endfunction

    function automatic logic [XLEN-1:0] scv_wide_of(input logic [31:0] w);
        return {w[31:30], 36'd0, w[25:0]};
    endfunction

    function automatic logic [XLEN-1:0] scv_reload(input scv_cfg_t c);
        logic [1:0] code;
        logic [3:0] fields;
        code   = c.xlen_is_64 ? XL_CODE_64 : XL_CODE_32;
        fields = {c.has_supervisor ? code : 2'b00, c.has_user ? code : 2'b00};
        return c.reset_value | {28'd0, fields, 32'd0};
    endfunction

endpackage

`default_nettype wire

>>> rtl/scv_update.sv
// Next-status and response logic for one status CSR transaction.
// Depends on scv_pkg.
`default_nettype none

module scv_update
    import scv_pkg::*;
(
    input  wire scv_req_t        req,
    input  wire scv_cfg_t        cfg,
    input  wire logic [XLEN-1:0] status,
    output logic [XLEN-1:0]      status_next,
    output scv_rsp_t             rsp
);

    logic [XLEN-1:0] mask;
    logic [XLEN-1:0] data;
    logic [XLEN-1:0] seen;
    logic [1:0]      mpp_code;
    logic            refuse;
    logic            updated;

    always_comb
    begin
        case (req.view)
            VIEW_MACHINE: mask = cfg.machine_write_mask;
            VIEW_SUPER:   mask = cfg.super_write_mask;
            VIEW_USER:    mask = cfg.user_write_mask;
            default:      mask = '0;
        endcase

        data = req.data_value;
        if (req.narrow_layout)
        begin
            mask = mask & NARROW_COVER;
            data = scv_wide_of(req.data_value[31:0]);
        end

        mpp_code = req.data_value[1:0];
        refuse   = ((mpp_code == 2'd0) && !cfg.has_user) ||
                   ((mpp_code == 2'd1) && !cfg.has_supervisor);

        status_next = status;
        updated     = 1'b0;
        case (req.command)
            CMD_WRITE:
            begin
                status_next = (status & ~mask) | (data & mask);
                updated     = 1'b1;
            end
            CMD_SET:
            begin
                status_next = status | (data & mask);
                updated     = 1'b1;
            end
            CMD_CLEAR:
            begin
                status_next = status & ~(data & mask);
                updated     = 1'b1;
            end
            CMD_MPP:
            begin
                if (!refuse)
                begin
                    status_next = status;
                    status_next[MPP_LSB +: 2] = mpp_code;
                    updated     = 1'b1;
                end
            end
            default:
            begin
                status_next = status;
                updated     = 1'b0;
            end
        endcase

        seen                = status_next & cfg.visible_mask;
        rsp.read_data       = req.narrow_layout ? scv_narrow_of(seen) : seen;
        rsp.interrupt_check = updated && (status_next[3:0] != 4'd0);
    end

endmodule

`default_nettype wire

>>> rtl/status_csr_views.sv
// Each transaction is held in the input register and its response in the output register.
// Throughput: one transaction per cycle unless out_ready stalls the output; status is updated
// as the item leaves the input register, so each item sees every earlier update.
// Reset: configuration returns to its defaults, status to the reset formula, both
// pipeline registers empty. Configuration writes are always ready.
// Depends on scv_pkg and scv_update.
`default_nettype none

module status_csr_views
    import scv_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire scv_req_t   in_item,
    output logic            out_valid,
    input  wire             out_ready,
    output scv_rsp_t        out_item,
    input  wire             cfg_valid,
    output logic            cfg_ready,
    input  wire [2:0]       cfg_index,
    input  wire [XLEN-1:0]  cfg_data
);

    scv_cfg_t        cfg_reg;
    scv_cfg_t        cfg_next;
    logic            reload;
    logic [XLEN-1:0] status_reg;
    logic [XLEN-1:0] status_next;
    logic [XLEN-1:0] upd_status;
    logic            s1_valid_reg;
    scv_req_t        s1_reg;
    logic            out_valid_reg;
    scv_rsp_t        out_reg;
    scv_rsp_t        upd_rsp;
    logic            s1_advance;

    scv_update u_update (
        .req         (s1_reg),
        .cfg         (cfg_reg),
        .status      (status_reg),
        .status_next (upd_status),
        .rsp         (upd_rsp)
    );

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        reload   = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RESET_VALUE:
                begin
                    cfg_next.reset_value = cfg_data;
                    reload               = 1'b1;
                end
                CFG_VISIBLE_MASK:  cfg_next.visible_mask       = cfg_data;
                CFG_MACHINE_WMASK: cfg_next.machine_write_mask = cfg_data;
                CFG_SUPER_WMASK:   cfg_next.super_write_mask   = cfg_data;
                CFG_USER_WMASK:    cfg_next.user_write_mask    = cfg_data;
                CFG_XLEN_IS_64:
                begin
                    cfg_next.xlen_is_64 = cfg_data[0];
                    reload              = 1'b1;
                end
                CFG_HAS_USER:
                begin
                    cfg_next.has_user = cfg_data[0];
                    reload            = 1'b1;
                end
                CFG_HAS_SUPER:
                begin
                    cfg_next.has_supervisor = cfg_data[0];
                    reload                  = 1'b1;
                end
                default: cfg_next = cfg_reg;
            endcase
        end

        if (reload)
            status_next = scv_reload(cfg_next);
        else if (s1_advance)
            status_next = upd_status;
        else
            status_next = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_AT_RESET;
            status_reg    <= scv_reload(CFG_AT_RESET);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            status_reg <= status_next;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // hold payload until the next stage takes it
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_reg <= in_item;
        if (s1_advance)
            out_reg <= upd_rsp;
    end

    a_status_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_advance && !cfg_valid) |=> $stable(status_reg))
        else $error("status changed without a transaction or configuration write");

    a_read_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (s1_reg.command == CMD_READ)) |=> !out_reg.interrupt_check)
        else $error("read raised the interrupt check");

    a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_reg.narrow_layout) |=> (out_reg.read_data[63:32] == 32'd0))
        else $error("narrow response has upper bits set");

    a_out_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_advance))
        else $error("response appeared without a transaction");

endmodule

`default_nettype wire

>>> tb/sv/status_csr_views_test.sv
// Self-checking bench for status_csr_views: queued CSR commands go through the
// valid/ready ports and each response is checked against a local status model.
// Depends on scv_pkg and the status_csr_views RTL.

module status_csr_views_test;
    import scv_pkg::*;

    localparam logic [1:0] PRIV_USER    = 2'd0;
    localparam logic [1:0] PRIV_SUPER   = 2'd1;
    localparam logic [1:0] PRIV_RSVD    = 2'd2;
    localparam logic [1:0] PRIV_MACHINE = 2'd3;
    localparam logic [1:0] VIEW_NONE    = 2'd3;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 7;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    scv_req_t        in_item = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    scv_rsp_t        out_item;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [2:0]      cfg_index = CFG_RESET_VALUE;
    logic [XLEN-1:0] cfg_data = '0;

    scv_cfg_t        cfg_model;
    logic [XLEN-1:0] status_model;
    scv_req_t        csr_pending[$];
    scv_rsp_t        rsp_expected[$];
    scv_rsp_t        rsp_head;

    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;
    int cycles = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int cfg_writes = 0;
    int irq_count = 0;
    int fail_count = 0;

    status_csr_views dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void status_reload();
        logic [1:0] xl;
        xl = cfg_model.xlen_is_64 ? XL_CODE_64 : XL_CODE_32;
        status_model = cfg_model.reset_value;
        if (cfg_model.has_user)
            status_model[33:32] = status_model[33:32] | xl;
        if (cfg_model.has_supervisor)
            status_model[35:34] = status_model[35:34] | xl;
    endfunction

    function automatic void cfg_apply(input logic [2:0] idx, input logic [XLEN-1:0] val);
        case (idx)
            CFG_RESET_VALUE:   begin cfg_model.reset_value = val; status_reload(); end
            CFG_VISIBLE_MASK:  cfg_model.visible_mask = val;
            CFG_MACHINE_WMASK: cfg_model.machine_write_mask = val;
            CFG_SUPER_WMASK:   cfg_model.super_write_mask = val;
            CFG_USER_WMASK:    cfg_model.user_write_mask = val;
            CFG_XLEN_IS_64:    begin cfg_model.xlen_is_64 = val[0]; status_reload(); end
            CFG_HAS_USER:      begin cfg_model.has_user = val[0]; status_reload(); end
            CFG_HAS_SUPER:     begin cfg_model.has_supervisor = val[0]; status_reload(); end
            default: ;
        endcase
    endfunction

    function automatic scv_rsp_t csr_execute(input scv_req_t r);
        logic [XLEN-1:0] wmask;
        logic [XLEN-1:0] wdata;
        logic [XLEN-1:0] seen;
        logic            changed;
        logic            refused;
        scv_rsp_t        rsp;
        changed = 1'b0;
        case (r.view)
            VIEW_MACHINE: wmask = cfg_model.machine_write_mask;
            VIEW_SUPER:   wmask = cfg_model.super_write_mask;
            VIEW_USER:    wmask = cfg_model.user_write_mask;
            default:      wmask = '0;
        endcase
        wdata = r.data_value;
        if (r.narrow_layout)
        begin
            wmask = wmask & NARROW_COVER;
            wdata = '0;
            wdata[25:0] = r.data_value[25:0];
            wdata[63:62] = r.data_value[31:30];
        end
        case (r.command)
            CMD_WRITE:
            begin
                status_model = (status_model & ~wmask) | (wdata & wmask);
                changed = 1'b1;
            end
            CMD_SET:
            begin
                status_model = status_model | (wdata & wmask);
                changed = 1'b1;
            end
            CMD_CLEAR:
            begin
                status_model = status_model & ~(wdata & wmask);
                changed = 1'b1;
            end
            CMD_MPP:
            begin
                refused = (r.data_value[1:0] == PRIV_USER && !cfg_model.has_user) ||
                          (r.data_value[1:0] == PRIV_SUPER && !cfg_model.has_supervisor);
                if (!refused)
                begin
                    status_model[MPP_LSB +: 2] = r.data_value[1:0];
                    changed = 1'b1;
                end
            end
            default: ;
        endcase
        seen = status_model & cfg_model.visible_mask;
        rsp.read_data = seen;
        if (r.narrow_layout)
        begin
            rsp.read_data = '0;
            rsp.read_data[29:0] = seen[29:0];
            rsp.read_data[31:30] = seen[63:62];
        end
        rsp.interrupt_check = changed && (status_model[3:0] != 4'd0);
        return rsp;
    endfunction

    function automatic logic [XLEN-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return 64'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [XLEN-1:0] random_mask();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic scv_req_t random_req();
        scv_req_t r;
        int       pick;
        pick = $urandom_range(0, 19);
        if (pick < 4)
            r.command = CMD_READ;
        else if (pick < 8)
            r.command = CMD_WRITE;
        else if (pick < 12)
            r.command = CMD_SET;
        else if (pick < 16)
            r.command = CMD_CLEAR;
        else if (pick < 19)
            r.command = CMD_MPP;
        else
            r.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        if ($urandom_range(0, 15) == 0)
            r.view = VIEW_NONE;
        else
            r.view = 2'($urandom_range(VIEW_MACHINE, VIEW_USER));
        r.narrow_layout = 1'($urandom_range(0, 1));
        r.data_value = random_word();
        return r;
    endfunction

    task automatic csr_queue(input logic [2:0] cmd, input logic [1:0] vw, input logic narrow,
                             input logic [XLEN-1:0] val);
        scv_req_t r;
        r.command = cmd;
        r.view = vw;
        r.narrow_layout = narrow;
        r.data_value = val;
        csr_pending.push_back(r);
    endtask

    task automatic wait_idle();
        while (csr_pending.size() != 0 || in_valid || rsp_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [XLEN-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_apply(idx, val);
        cfg_writes++;
    endtask

    task automatic cfg_program(input scv_cfg_t c);
        cfg_write(CFG_VISIBLE_MASK, c.visible_mask);
        cfg_write(CFG_MACHINE_WMASK, c.machine_write_mask);
        cfg_write(CFG_SUPER_WMASK, c.super_write_mask);
        cfg_write(CFG_USER_WMASK, c.user_write_mask);
        cfg_write(CFG_XLEN_IS_64, {63'd0, c.xlen_is_64});
        cfg_write(CFG_HAS_USER, {63'd0, c.has_user});
        cfg_write(CFG_HAS_SUPER, {63'd0, c.has_supervisor});
        cfg_write(CFG_RESET_VALUE, c.reset_value);
    endtask

    // hold the sender halfway until the pipeline has drained
    task automatic random_items(input int count);
        for (int k = 0; k < count; k++)
        begin
            csr_pending.push_back(random_req());
            if (k == count / 2)
                wait_idle();
        end
        wait_idle();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                rsp_expected.push_back(csr_execute(in_item));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 || csr_pending.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_item <= csr_pending.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $display("%0t: unexpected transaction read_data=%h interrupt_check=%b",
                             $time, out_item.read_data, out_item.interrupt_check);
                    fail_count++;
                end
                else
                begin
                    rsp_head = rsp_expected.pop_front();
                    if (out_item.read_data !== rsp_head.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, rsp_head.read_data, out_item.read_data);
                        fail_count++;
                    end
                    if (out_item.interrupt_check !== rsp_head.interrupt_check)
                    begin
                        $display("%0t: interrupt_check expected %b actual %b",
                                 $time, rsp_head.interrupt_check, out_item.interrupt_check);
                        fail_count++;
                    end
                    if (out_item.interrupt_check === 1'b1)
                        irq_count++;
                    checked_count++;
                end
            end
            stall_phase <= stall_phase + 1;
            case (stall_phase[8:7])
                2'd0:    out_ready <= 1'b1;
                2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
                2'd2:    out_ready <= (stall_phase[3:0] < 4'd10);
                default: out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: run stopped at cycle limit, %0d transactions outstanding",
                     $time, rsp_expected.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        scv_cfg_t pick;
        cfg_model = CFG_AT_RESET;
        status_reload();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        csr_queue(CMD_READ, VIEW_MACHINE, 1'b0, '0);
        csr_queue(CMD_READ, VIEW_MACHINE, 1'b1, '0);
        csr_queue(CMD_WRITE, VIEW_MACHINE, 1'b0, '1);
        csr_queue(CMD_READ, VIEW_MACHINE, 1'b1, '0);
        csr_queue(CMD_CLEAR, VIEW_MACHINE, 1'b0, 64'hF);
        csr_queue(CMD_WRITE, VIEW_MACHINE, 1'b1, '1);
        csr_queue(CMD_WRITE, VIEW_MACHINE, 1'b1, '0);
        csr_queue(CMD_SET, VIEW_MACHINE, 1'b0, 64'h5);
        csr_queue(CMD_WRITE, VIEW_SUPER, 1'b0, '1);
        csr_queue(CMD_CLEAR, VIEW_USER, 1'b1, '1);
        csr_queue(CMD_WRITE, VIEW_NONE, 1'b0, '0);
        csr_queue(CMD_SPARE_LO, VIEW_MACHINE, 1'b0, '1);
        csr_queue(CMD_SPARE_MID, VIEW_SUPER, 1'b1, '1);
        csr_queue(CMD_SPARE_HI, VIEW_USER, 1'b0, '1);
        csr_queue(CMD_MPP, VIEW_MACHINE, 1'b0, {62'd0, PRIV_USER});
        csr_queue(CMD_MPP, VIEW_SUPER, 1'b1, {62'd0, PRIV_SUPER});
        csr_queue(CMD_MPP, VIEW_USER, 1'b0, {62'd0, PRIV_RSVD});
        csr_queue(CMD_MPP, VIEW_NONE, 1'b0, {62'h3FFF_FFFF_FFFF_FFFF, PRIV_MACHINE});
        csr_queue(CMD_WRITE, VIEW_MACHINE, 1'b0, '0);
        csr_queue(CMD_READ, VIEW_MACHINE, 1'b0, '0);
        wait_idle();
        random_items(80);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    pick = '{'1, '1, '1, '1, '1, 1'b0, 1'b0, 1'b0};
                    cfg_program(pick);
                    csr_queue(CMD_MPP, VIEW_MACHINE, 1'b0, {62'd0, PRIV_USER});
                    csr_queue(CMD_MPP, VIEW_MACHINE, 1'b0, {62'd0, PRIV_SUPER});
                    csr_queue(CMD_MPP, VIEW_MACHINE, 1'b1, {62'd0, PRIV_RSVD});
                end
                1:
                begin
                    pick = '{'0, '0, '0, '0, '0, 1'b1, 1'b1, 1'b0};
                    cfg_program(pick);
                end
                default:
                begin
                    pick.reset_value = random_word();
                    pick.visible_mask = random_mask();
                    pick.machine_write_mask = random_mask();
                    pick.super_write_mask = random_mask();
                    pick.user_write_mask = random_mask();
                    pick.xlen_is_64 = 1'($urandom_range(0, 1));
                    pick.has_user = 1'($urandom_range(0, 1));
                    pick.has_supervisor = 1'($urandom_range(0, 1));
                    cfg_program(pick);
                end
            endcase
            random_items(95);
        end

        repeat (10) @(posedge clk);
        $display("Ran %0d CSR transactions over %0d register settings, %0d config writes.",
                 accepted_count, RANDOM_PHASES + 1, cfg_writes);
        $display("Checked %0d responses, %0d of them raising interrupt_check.",
                 checked_count, irq_count);
        if (fail_count == 0 && rsp_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
